### design/color_ramp_crossfade_top_assert.svh
// Assertion macros for the color ramp crossfade checker.
// No dependencies; included by the checker file only.
`ifndef COLOR_RAMP_CROSSFADE_TOP_ASSERT_SVH
`define COLOR_RAMP_CROSSFADE_TOP_ASSERT_SVH

// Check that ante implies cons, outside reset.
`define RCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that expr holds on every clock outside reset.
`define RCF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

### design/rcf_pkg.sv
// Shared types and constants for the color ramp crossfade block.
// No dependencies; imported by every module of the block.
package rcf_pkg;

    typedef logic [7:0] chan_t;
    typedef chan_t [0:2] rgb_t;

    typedef struct packed {
        logic  valid;
        chan_t entry;
    } rcf_tag_t;

    localparam int RGB_LANES = 3;
    localparam int MAX_SLOTS = 8;
    localparam int NUM_STOPS = 4;

    localparam chan_t      SEG_LEN  = 8'd85;
    localparam chan_t      SEG_TWO  = 8'd170;
    localparam chan_t      POS_MAX  = 8'd255;
    localparam logic [6:0] LAST_OFF = 7'd85;

    localparam logic [1:0] CFG_RAMP_FIRST   = 2'd0;
    localparam logic [1:0] CFG_RAMP_SECOND  = 2'd1;
    localparam logic [1:0] CFG_BLEND_WEIGHT = 2'd2;

    localparam rgb_t RAMP_TABLE [MAX_SLOTS][NUM_STOPS] = '{
        '{'{8'd0,   8'd0,   8'd0  }, '{8'd6,   8'd14,  8'd28 },
          '{8'd40,  8'd84,  8'd126}, '{8'd188, 8'd214, 8'd238}},
        '{'{8'd4,   8'd2,   8'd6  }, '{8'd62,  8'd14,  8'd10 },
          '{8'd178, 8'd72,  8'd16 }, '{8'd248, 8'd196, 8'd96 }},
        '{'{8'd12,  8'd4,   8'd18 }, '{8'd124, 8'd24,  8'd92 },
          '{8'd242, 8'd110, 8'd52 }, '{8'd255, 8'd255, 8'd240}},
        '{'{8'd0,   8'd0,   8'd0  }, '{8'd18,  8'd18,  8'd22 },
          '{8'd58,  8'd56,  8'd60 }, '{8'd126, 8'd124, 8'd130}},
        '{'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}},
        '{'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}},
        '{'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}},
        '{'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}}
    };

endpackage

### design/rcf_lookup.sv
// Segment decode and ramp stop lookup stage of the color ramp crossfade block.
// Depends on rcf_pkg for the stop table and tag type.
module rcf_lookup
    import rcf_pkg::*;
#(
    parameter int NUM_RAMPS = 5
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rcf_tag_t                    tag_in,
    input  logic [2:0]                  sel_first,
    input  logic [2:0]                  sel_second,
    output rcf_tag_t                    tag_out,
    output chan_t                       pos,
    output logic [2*RGB_LANES-1:0][7:0] lo,
    output logic [2*RGB_LANES-1:0][7:0] hi
);

    logic [1:0]                  seg;
    logic [6:0]                  off;
    chan_t                       pos_next;
    logic [2:0]                  ramp_a;
    logic [2:0]                  ramp_b;
    logic [2*RGB_LANES-1:0][7:0] lo_next;
    logic [2*RGB_LANES-1:0][7:0] hi_next;

    logic                        valid_reg;
    chan_t                       entry_reg;
    chan_t                       pos_reg;
    logic [2*RGB_LANES-1:0][7:0] lo_reg;
    logic [2*RGB_LANES-1:0][7:0] hi_reg;

    always_comb
    begin
        priority if (tag_in.entry < SEG_LEN)
        begin
            seg = 2'd0;
            off = tag_in.entry[6:0];
        end
        else if (tag_in.entry < SEG_TWO)
        begin
            seg = 2'd1;
            off = 7'(tag_in.entry - SEG_LEN);
        end
        else
        begin
            seg = 2'd2;
            off = 7'(tag_in.entry - SEG_TWO);
        end
        // clamp the last-segment endpoint; elsewhere 256/85 scaling is 3*off
        if (off == LAST_OFF)
        begin
            pos_next = POS_MAX;
        end
        else
        begin
            pos_next = {1'b0, off} + {off, 1'b0};
        end
        ramp_a = ({1'b0, sel_first} >= 4'(NUM_RAMPS)) ? 3'd0 : sel_first;
        ramp_b = ({1'b0, sel_second} >= 4'(NUM_RAMPS)) ? 3'd0 : sel_second;
        for (int c = 0; c < RGB_LANES; c++)
        begin
            lo_next[c]             = RAMP_TABLE[ramp_a][seg][c];
            hi_next[c]             = RAMP_TABLE[ramp_a][seg + 2'd1][c];
            lo_next[c + RGB_LANES] = RAMP_TABLE[ramp_b][seg][c];
            hi_next[c + RGB_LANES] = RAMP_TABLE[ramp_b][seg + 2'd1][c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= tag_in.entry;
        pos_reg   <= pos_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
    end

    assign tag_out.valid = valid_reg;
    assign tag_out.entry = entry_reg;
    assign pos           = pos_reg;
    assign lo            = lo_reg;
    assign hi            = hi_reg;

endmodule

### design/rcf_lerp.sv
// Two-stage linear interpolation lanes: multiply stage, then add stage.
// Depends on rcf_pkg for the tag and channel types.
module rcf_lerp
    import rcf_pkg::*;
#(
    parameter int LANES = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcf_tag_t              tag_in,
    input  logic [LANES-1:0][7:0] lo,
    input  logic [LANES-1:0][7:0] hi,
    input  chan_t                 weight,
    output rcf_tag_t              tag_out,
    output logic [LANES-1:0][7:0] mix
);

    logic signed [8:0]     diff      [LANES];
    logic signed [17:0]    prod_next [LANES];
    logic [9:0]            sum       [LANES];
    logic [LANES-1:0][7:0] mix_next;

    logic                  valid_a_reg;
    logic                  valid_b_reg;
    chan_t                 entry_a_reg;
    chan_t                 entry_b_reg;
    logic signed [17:0]    prod_reg  [LANES];
    logic [LANES-1:0][7:0] lo_reg;
    logic [LANES-1:0][7:0] mix_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            diff[i]      = $signed({1'b0, hi[i]}) - $signed({1'b0, lo[i]});
            prod_next[i] = 18'(diff[i]) * 18'($signed({1'b0, weight}));
            // floor shift of the product, then wrap to eight bits
            sum[i]       = {2'b00, lo_reg[i]} + prod_reg[i][17:8];
            mix_next[i]  = sum[i][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= tag_in.valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_a_reg <= tag_in.entry;
        entry_b_reg <= entry_a_reg;
        lo_reg      <= lo;
        prod_reg    <= prod_next;
        mix_reg     <= mix_next;
    end

    assign tag_out.valid = valid_b_reg;
    assign tag_out.entry = entry_b_reg;
    assign mix           = mix_reg;

endmodule

### design/color_ramp_crossfade_top.sv
// A start's color reaches done via the lookup, ramp and fade registers.
// Throughput: one entry per cycle; busy stays low, the pipeline never stalls.
// Stages: stop lookup (1), ramp interpolation (2), crossfade (2).
// Reset clears the pipeline valid bits and all configuration registers.
// Depends on rcf_pkg, rcf_lookup and rcf_lerp.
module color_ramp_crossfade_top
    import rcf_pkg::*;
#(
    parameter int NUM_RAMPS = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] entry_index,
    output logic       done,
    output logic [7:0] entry_out,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [2:0] ramp_first_reg;
    logic [2:0] ramp_second_reg;
    chan_t      blend_weight_reg;

    rcf_tag_t                    tag_in;
    rcf_tag_t                    tag_look;
    rcf_tag_t                    tag_ramp;
    rcf_tag_t                    tag_fade;
    chan_t                       pos;
    logic [2*RGB_LANES-1:0][7:0] lo;
    logic [2*RGB_LANES-1:0][7:0] hi;
    logic [2*RGB_LANES-1:0][7:0] ramp_rgb;
    logic [RGB_LANES-1:0][7:0]   fade_rgb;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_first_reg   <= '0;
            ramp_second_reg  <= '0;
            blend_weight_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RAMP_FIRST:   ramp_first_reg   <= cfg_data[2:0];
                CFG_RAMP_SECOND:  ramp_second_reg  <= cfg_data[2:0];
                CFG_BLEND_WEIGHT: blend_weight_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign tag_in.valid = start && !busy;
    assign tag_in.entry = entry_index;

    rcf_lookup #(
        .NUM_RAMPS (NUM_RAMPS)
    ) u_lookup (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag_in     (tag_in),
        .sel_first  (ramp_first_reg),
        .sel_second (ramp_second_reg),
        .tag_out    (tag_look),
        .pos        (pos),
        .lo         (lo),
        .hi         (hi)
    );

    rcf_lerp #(
        .LANES (2*RGB_LANES)
    ) u_ramp (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_look),
        .lo      (lo),
        .hi      (hi),
        .weight  (pos),
        .tag_out (tag_ramp),
        .mix     (ramp_rgb)
    );

    rcf_lerp #(
        .LANES (RGB_LANES)
    ) u_fade (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_ramp),
        .lo      (ramp_rgb[RGB_LANES-1:0]),
        .hi      (ramp_rgb[2*RGB_LANES-1:RGB_LANES]),
        .weight  (blend_weight_reg),
        .tag_out (tag_fade),
        .mix     (fade_rgb)
    );

    assign done      = tag_fade.valid;
    assign entry_out = tag_fade.entry;
    assign red       = fade_rgb[0];
    assign green     = fade_rgb[1];
    assign blue      = fade_rgb[2];

endmodule

### design/rcf_checker.sv
// Port-level checker for color_ramp_crossfade_top, bound to the top level.
// Depends on color_ramp_crossfade_top_assert.svh for the assertion macros.
`include "color_ramp_crossfade_top_assert.svh"

module rcf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] entry_index,
    input logic       done,
    input logic [7:0] entry_out,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    `RCF_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `RCF_ASSERT_IMPL(a_start_done, clk, rst_n, start && !busy, ##5 done)
    `RCF_ASSERT_IMPL(a_done_start, clk, rst_n, done, $past(start && !busy, 5))
    `RCF_ASSERT_IMPL(a_entry_echo, clk, rst_n, done, entry_out == $past(entry_index, 5))
    `RCF_ASSERT_IMPL(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind color_ramp_crossfade_top rcf_checker u_rcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .entry_index (entry_index),
    .done        (done),
    .entry_out   (entry_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);
